// ===== design/ecu_pkg.sv =====
// Shared types, widths and helpers for the eikonal upwind cell update core.
// Used by every module in the design folder.
package ecu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int W         = 18;                 // potential / cost width
  localparam logic [W-1:0] MAX_CODE = W'(1000 << FRAC_BITS);
  localparam int AW        = 2 * W + 1;          // cx^2 + cy^2
  localparam int SQ_EXTRA  = 12;                 // fraction bits of the root
  localparam int RW        = (AW + 2 * SQ_EXTRA + 1) / 2;  // root width
  localparam int REMW      = RW + 3;             // sqrt partial remainder
  localparam int EPAIRS    = (AW + 1) / 2;       // radicand pairs coming from e
  localparam int NW        = 3 * W + 3;          // numerator width
  localparam int IN_BYTES  = (8 * W + 4 + 7) / 8;
  localparam int OUT_BYTES = (W + 7) / 8;

  typedef struct packed {
    logic [W-1:0]  px;
    logic [W-1:0]  py;
    logic [W-1:0]  cx;
    logic [W-1:0]  cy;
    logic [AW-1:0] a;
    logic [W-1:0]  hi;     // larger chosen potential
    logic [W-1:0]  fb;     // fallback result (saturated)
    logic          early;  // result is fb, root not used
  } ecu_side_t;

  function automatic logic [W-1:0] sat_w(input logic [W:0] v);
    return (v > {1'b0, MAX_CODE}) ? MAX_CODE : v[W-1:0];
  endfunction

endpackage

// ===== design/ecu_front.sv =====
// Axis pick, squares and discriminant: three register stages.
// Depends on ecu_pkg.
module ecu_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [8*ecu_pkg::W+3:0] item_i,
  output logic                    valid_o,
  output ecu_pkg::ecu_side_t      side_o,
  output logic [ecu_pkg::AW-1:0]  e_o
);
  import ecu_pkg::*;

  logic [W-1:0] pe, pw, pn, ps, ce, cw, cn, cs;
  logic         he, hw, hn, hs;
  logic [W-1:0] px_d, cx_d, py_d, cy_d;
  logic [W-1:0] px_q, cx_q, py_q, cy_q;
  logic [W:0]   se, sw, sn, ss;
  logic [2:0]   vld_q;

  assign {hs, hn, hw, he, cs, cn, cw, ce, ps, pn, pw, pe} = item_i;
  assign se = {1'b0, pe} + {1'b0, ce};
  assign sw = {1'b0, pw} + {1'b0, cw};
  assign sn = {1'b0, pn} + {1'b0, cn};
  assign ss = {1'b0, ps} + {1'b0, cs};

  always_comb begin
    priority if (he && !hw) begin
      px_d = pe; cx_d = ce;
    end else if (!he && hw) begin
      px_d = pw; cx_d = cw;
    end else if (!he && !hw) begin
      px_d = MAX_CODE; cx_d = MAX_CODE;
    end else if (se < sw) begin
      px_d = pe; cx_d = ce;
    end else begin
      px_d = pw; cx_d = cw;
    end
    priority if (hn && !hs) begin
      py_d = pn; cy_d = cn;
    end else if (!hn && hs) begin
      py_d = ps; cy_d = cs;
    end else if (!hn && !hs) begin
      py_d = MAX_CODE; cy_d = MAX_CODE;
    end else if (sn < ss) begin
      py_d = pn; cy_d = cn;
    end else begin
      py_d = ps; cy_d = cs;
    end
  end

  // stage 2: squares and fallback
  logic [W:0]     sx, sy, smin;
  logic [W-1:0]   d;
  logic [2*W-1:0] cx2_q, cy2_q, d2_q;
  ecu_side_t      s2_d, s2_q, s3_d, s3_q;
  logic [AW-1:0]  a3, e_q;

  assign sx   = {1'b0, px_q} + {1'b0, cx_q};
  assign sy   = {1'b0, py_q} + {1'b0, cy_q};
  assign smin = (sx < sy) ? sx : sy;
  assign d    = (px_q > py_q) ? px_q - py_q : py_q - px_q;

  always_comb begin
    s2_d       = '0;
    s2_d.px    = px_q;
    s2_d.py    = py_q;
    s2_d.cx    = cx_q;
    s2_d.cy    = cy_q;
    s2_d.hi    = (px_q > py_q) ? px_q : py_q;
    s2_d.early = 1'b1;
    priority if (px_q >= MAX_CODE && py_q >= MAX_CODE) begin
      s2_d.fb = MAX_CODE;
    end else if (px_q >= MAX_CODE) begin
      s2_d.fb = sat_w(sy);
    end else if (py_q >= MAX_CODE) begin
      s2_d.fb = sat_w(sx);
    end else begin
      s2_d.fb    = sat_w(smin);
      s2_d.early = 1'b0;
    end
  end

  // stage 3: A and E = A - d^2
  assign a3 = {1'b0, cx2_q} + {1'b0, cy2_q};
  always_comb begin
    s3_d   = s2_q;
    s3_d.a = a3;
    if (a3 == '0 || {1'b0, d2_q} > a3) begin
      s3_d.early = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      cx_q  <= cx_d;
      py_q  <= py_d;
      cy_q  <= cy_d;
      cx2_q <= cx_q * cx_q;
      cy2_q <= cy_q * cy_q;
      d2_q  <= d * d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      e_q   <= a3 - {1'b0, d2_q};
    end
  end

  assign valid_o = vld_q[2];
  assign side_o  = s3_q;
  assign e_o     = e_q;
endmodule

// ===== design/ecu_isqrt.sv =====
// Pipelined integer square root of E << 24, one root bit per stage.
// Depends on ecu_pkg.
module ecu_isqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  ecu_pkg::ecu_side_t     side_i,
  input  logic [ecu_pkg::AW-1:0] e_i,
  output logic                   valid_o,
  output ecu_pkg::ecu_side_t     side_o,
  output logic [ecu_pkg::RW-1:0] root_o
);
  import ecu_pkg::*;

  logic [RW:0]          vld_q;
  ecu_side_t            side_q [RW+1];
  logic [2*EPAIRS-1:0]  rad_q  [RW+1];
  logic [REMW-1:0]      rem_q  [RW+1];
  logic [RW-1:0]        root_q [RW+1];

  assign vld_q[0]  = valid_i;
  assign side_q[0] = side_i;
  assign rad_q[0]  = (2*EPAIRS)'(e_i);
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [1:0]      pair;
    logic [REMW-1:0] rem_n, trial;

    if (i < EPAIRS) begin : g_epair
      assign pair = rad_q[i][2*EPAIRS-1-2*i -: 2];
    end else begin : g_zpair
      assign pair = 2'b00;
    end
    assign rem_n = {rem_q[i][REMW-3:0], pair};
    assign trial = REMW'({root_q[i], 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        rad_q[i+1]  <= rad_q[i];
        if (rem_n >= trial) begin
          rem_q[i+1]  <= rem_n - trial;
          root_q[i+1] <= {root_q[i][RW-2:0], 1'b1};
        end else begin
          rem_q[i+1]  <= rem_n;
          root_q[i+1] <= {root_q[i][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[RW];
  assign side_o  = side_q[RW];
  assign root_o  = root_q[RW];
endmodule

// ===== design/ecu_mul.sv =====
// Numerator px*cy^2 + py*cx^2 + ((cx*r) >> 12)*cy over three stages.
// Depends on ecu_pkg.
module ecu_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  ecu_pkg::ecu_side_t     side_i,
  input  logic [ecu_pkg::RW-1:0] root_i,
  output logic                   valid_o,
  output ecu_pkg::ecu_side_t     side_o,
  output logic [ecu_pkg::NW-1:0] num_o
);
  import ecu_pkg::*;

  localparam int CRW = W + RW;

  logic [2:0]         vld_q;
  ecu_side_t          s1_q, s2_q, s3_q;
  logic [CRW-1:0]     cxr_q;
  logic [2*W-1:0]     pxcy_q, pycx_q;
  logic [CRW-SQ_EXTRA+W-1:0] t_q;
  logic [3*W-1:0]     a1_q, a2_q;
  logic [NW-1:0]      num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= side_i;
      cxr_q  <= side_i.cx * root_i;
      pxcy_q <= side_i.px * side_i.cy;
      pycx_q <= side_i.py * side_i.cx;
      s2_q   <= s1_q;
      t_q    <= cxr_q[CRW-1:SQ_EXTRA] * s1_q.cy;
      a1_q   <= pxcy_q * s1_q.cy;
      a2_q   <= pycx_q * s1_q.cx;
      s3_q   <= s2_q;
      num_q  <= NW'(t_q) + NW'(a1_q) + NW'(a2_q);
    end
  end

  assign valid_o = vld_q[2];
  assign side_o  = s3_q;
  assign num_o   = num_q;
endmodule

// ===== design/ecu_div.sv =====
// Restoring divider num / A, one quotient bit per stage, with overflow
// detect and the final select into the output register. Depends on ecu_pkg.
module ecu_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  ecu_pkg::ecu_side_t     side_i,
  input  logic [ecu_pkg::NW-1:0] num_i,
  output logic                   valid_o,
  output logic [ecu_pkg::W-1:0]  result_o
);
  import ecu_pkg::*;

  logic [W+1:0]   vld_q;
  ecu_side_t      side_q [W+1];
  logic [NW-1:0]  rem_q  [W+1];
  logic [W-1:0]   quo_q  [W+1];
  logic           ovf_q  [W+1];
  logic [W-1:0]   res_q;
  logic [W-1:0]   u;

  // quotient does not fit in W bits: saturates anyway
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      rem_q[0]  <= num_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= num_i >= NW'({side_i.a, {W{1'b0}}});
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [NW-1:0] trial;
    assign trial = NW'({side_q[i].a, {(W-1-i){1'b0}}});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        ovf_q[i+1]  <= ovf_q[i];
        if (rem_q[i] >= trial) begin
          rem_q[i+1] <= rem_q[i] - trial;
          quo_q[i+1] <= {quo_q[i][W-2:0], 1'b1};
        end else begin
          rem_q[i+1] <= rem_q[i];
          quo_q[i+1] <= {quo_q[i][W-2:0], 1'b0};
        end
      end
    end
  end

  assign u = ovf_q[W] ? MAX_CODE : sat_w({1'b0, quo_q[W]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[W+1] <= 1'b0;
    end else if (en_i) begin
      vld_q[W+1] <= vld_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (side_q[W].early) begin
        res_q <= side_q[W].fb;
      end else if (ovf_q[W] || quo_q[W] > side_q[W].hi) begin
        res_q <= u;
      end else begin
        res_q <= side_q[W].fb;
      end
    end
  end

  assign valid_o  = vld_q[W+1];
  assign result_o = res_q;
endmodule

// ===== design/eikonal_upwind_cell_update_core.sv =====
// Eikonal upwind cell update: one cell potential per beat from four neighbour
// potentials, crossing costs and presence flags, in unsigned Q10.8 saturated
// at the max-cost code 256000. Fully pipelined: a new beat is taken every
// cycle while the output is not stalled. A beat passes through 3 front stages,
// 31 square root stages, 3 multiply stages, 19 divider stages and 1 select and
// output register; the root and divider resolve one bit per stage. When the output beat
// is not taken the whole pipeline holds. Depends on ecu_pkg and all ecu_ modules.
module eikonal_upwind_cell_update_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // pot_east, pot_west, pot_north, pot_south, cost_east, cost_west,
  // cost_north, cost_south (18 b each), has_east, has_west, has_north,
  // has_south (1 b each), zero fill
  input  logic [8*ecu_pkg::IN_BYTES-1:0]        s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // new_potential (18 b), zero fill
  output logic [8*ecu_pkg::OUT_BYTES-1:0]       m_axis_tdata_o
);
  import ecu_pkg::*;

  logic      en;
  logic      v_f, v_s, v_m, v_d;
  ecu_side_t sd_f, sd_s, sd_m;
  logic [AW-1:0] e_f;
  logic [RW-1:0] root;
  logic [NW-1:0] num;
  logic [W-1:0]  res;

  // advance unless the output beat is waiting
  assign en              = !v_d || m_axis_tready_i;
  assign s_axis_tready_o = en;

  ecu_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid_i),
    .item_i(s_axis_tdata_i[8*W+3:0]),
    .valid_o(v_f), .side_o(sd_f), .e_o(e_f)
  );

  ecu_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_f), .side_i(sd_f), .e_i(e_f),
    .valid_o(v_s), .side_o(sd_s), .root_o(root)
  );

  ecu_mul u_mul (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_s), .side_i(sd_s), .root_i(root),
    .valid_o(v_m), .side_o(sd_m), .num_o(num)
  );

  ecu_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_m), .side_i(sd_m), .num_i(num),
    .valid_o(v_d), .result_o(res)
  );

  assign m_axis_tvalid_o = v_d;
  assign m_axis_tdata_o  = (8*OUT_BYTES)'(res);
endmodule

// ===== test/tb_eikonal_upwind_cell_update_core.sv =====
// Testbench for eikonal_upwind_cell_update_core: directed and random cells, bursty sender,
// stalling receiver, results checked in order against a local cell-potential predictor.
// Depends on ecu_pkg and the design folder.
`timescale 1ns / 1ps

module tb_eikonal_upwind_cell_update_core;
  import ecu_pkg::*;

  localparam int DW    = 8 * IN_BYTES;
  localparam int QW    = 8 * OUT_BYTES;
  localparam int LIMIT = 400000;
  localparam logic [W-1:0] FMAX = '1;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [DW-1:0] s_axis_tdata_i = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [QW-1:0] m_axis_tdata_o;

  typedef struct {
    logic [W-1:0] pot[4];   // east, west, north, south
    logic [W-1:0] cost[4];
    logic         has[4];
  } cell_t;

  logic [W-1:0] expected_potentials[$];
  int unsigned  n_cycles, n_errors, n_cells, n_results;
  int unsigned  burst_left;
  int           stall_mode;  // 0 always ready, 1 random, 2 long periodic stalls

  eikonal_upwind_cell_update_core u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [W-1:0] clamp(input longint unsigned v);
    return (v > MAX_CODE) ? MAX_CODE : v[W-1:0];
  endfunction

  // Upwind pick on one axis: the second neighbour (west / south) wins a tie.
  function automatic void upwind(input longint unsigned p1, c1, input logic h1,
                                 input longint unsigned p2, c2, input logic h2,
                                 output longint unsigned p, c);
    if (h1 && !h2) begin
      p = p1; c = c1;
    end else if (!h1 && h2) begin
      p = p2; c = c2;
    end else if (!h1 && !h2) begin
      p = MAX_CODE; c = MAX_CODE;
    end else if (p1 + c1 < p2 + c2) begin
      p = p1; c = c1;
    end else begin
      p = p2; c = c2;
    end
  endfunction

  function automatic logic [W-1:0] cell_potential(input logic [DW-1:0] d);
    longint unsigned px, cx, py, cy, sx, sy, smin, a, dd, e, r, num, u, hi;
    upwind(d[0*W+:W], d[4*W+:W], d[8*W], d[1*W+:W], d[5*W+:W], d[8*W+1], px, cx);
    upwind(d[2*W+:W], d[6*W+:W], d[8*W+2], d[3*W+:W], d[7*W+:W], d[8*W+3], py, cy);
    sx   = px + cx;
    sy   = py + cy;
    smin = (sx < sy) ? sx : sy;
    if (px >= MAX_CODE && py >= MAX_CODE) return MAX_CODE;
    if (px >= MAX_CODE) return clamp(sy);
    if (py >= MAX_CODE) return clamp(sx);
    a  = cx * cx + cy * cy;
    dd = (px > py) ? px - py : py - px;
    dd = dd * dd;
    if (a == 0 || dd > a) return clamp(smin);
    e   = a - dd;
    r   = int_sqrt(e << (2 * SQ_EXTRA));
    num = px * cy * cy + py * cx * cx + ((cx * r) >> SQ_EXTRA) * cy;
    u   = num / a;
    hi  = (px > py) ? px : py;
    return (u > hi) ? clamp(u) : clamp(smin);
  endfunction

  function automatic logic [DW-1:0] pack_cell(input cell_t c);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < 4; i++) begin
      d[i*W+:W]     = c.pot[i];
      d[(4+i)*W+:W] = c.cost[i];
      d[8*W+i]      = c.has[i];
    end
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got, exp_v);
    n_errors++;
    $display("MISMATCH %s at cycle %0d: got %0d expected %0d", what, n_cycles, got, exp_v);
  endtask

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", expected_potentials.size());
      $display("tb_eikonal_upwind_cell_update_core NOT OK");
      $finish;
    end
  end

  // Predict on each accepted cell beat, check each accepted result beat.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_potentials.push_back(cell_potential(s_axis_tdata_i));
      n_cells++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (expected_potentials.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata_o[W-1:0], '0);
      end else begin
        if (m_axis_tdata_o[W-1:0] !== expected_potentials[0])
          report_mismatch("new_potential", m_axis_tdata_o[W-1:0], expected_potentials[0]);
        if (m_axis_tdata_o[QW-1:W] !== '0)
          report_mismatch("zero fill", m_axis_tdata_o[QW-1:W], '0);
        void'(expected_potentials.pop_front());
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready_i <= ((n_cycles % 37) > 25) ? 1'b0 : 1'b1;
    endcase
  end

  // Send one cell; when bursty, bursts of random length are separated by random gaps.
  task automatic send_cell(input cell_t c, input bit bursty);
    @(negedge clk_i);
    if (bursty && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pack_cell(c);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (expected_potentials.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [W-1:0] rand_code();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MAX_CODE;
      2: return FMAX;
      3: return MAX_CODE - 1;
      4: return W'($urandom_range(0, 255));
      5: return W'($urandom_range(MAX_CODE - 2000, FMAX));
      default: return W'($urandom_range(0, FMAX));
    endcase
  endfunction

  // Mostly realistic cells: close potentials and moderate costs so the root is used.
  function automatic cell_t rand_cell();
    cell_t c;
    logic [W-1:0] base;
    base = W'($urandom_range(0, 200000));
    for (int i = 0; i < 4; i++) begin
      c.has[i] = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) != 0) begin
        c.pot[i]  = base + W'($urandom_range(0, 4000));
        c.cost[i] = W'($urandom_range(1, 3000));
      end else begin
        c.pot[i]  = rand_code();
        c.cost[i] = rand_code();
      end
    end
    return c;
  endfunction

  function automatic cell_t make_cell(input logic [W-1:0] p, cst, input logic [3:0] h);
    cell_t c;
    for (int i = 0; i < 4; i++) begin
      c.pot[i] = p; c.cost[i] = cst; c.has[i] = h[i];
    end
    return c;
  endfunction

  task automatic test_directed();
    cell_t c;
    stall_mode = 0;
    send_cell(make_cell('0, '0, 4'hF), 0);              // zero costs
    send_cell(make_cell(FMAX, FMAX, 4'hF), 0);          // all fields at top
    send_cell(make_cell(1000, 256, 4'h0), 0);           // no neighbours at all
    for (int i = 0; i < 4; i++)                         // one neighbour each
      send_cell(make_cell(1000, 256, 4'(1 << i)), 0);
    send_cell(make_cell(1000, 256, 4'h5), 0);           // east and north only
    send_cell(make_cell(MAX_CODE, 256, 4'hF), 0);       // potentials at max
    send_cell(make_cell(MAX_CODE - 1, 256, 4'hF), 0);
    send_cell(make_cell(200000, 200000, 4'hF), 0);      // saturating sums
    send_cell(make_cell(5000, 256, 4'hF), 0);           // equal axes, root path
    c = make_cell(1000, 100, 4'hF);                     // tie on east/west sums
    c.pot[0] = 900; c.cost[0] = 200;
    send_cell(c, 0);
    c = make_cell(1000, 100, 4'hF);                     // tie on north/south sums
    c.pot[2] = 1100; c.cost[2] = 0; c.cost[3] = 100;
    send_cell(c, 0);
    c = make_cell(0, 10, 4'hF);                         // no real root
    c.pot[2] = 50000; c.pot[3] = 50000;
    send_cell(c, 0);
    c = make_cell(0, 0, 4'hF);                          // zero costs, distinct potentials
    c.pot[2] = 3000; c.pot[3] = 3000;
    send_cell(c, 0);
    c = make_cell(0, 256, 4'hF);                        // one axis above max
    c.pot[2] = FMAX; c.pot[3] = FMAX;
    send_cell(c, 0);
    c = make_cell(255000, 5000, 4'hF);                  // root above max code
    send_cell(c, 0);
    drain();
  endtask

  task automatic test_random(input int count, input int mode);
    stall_mode = mode;
    burst_left = 0;
    for (int i = 0; i < count; i++) send_cell(rand_cell(), 1);
    stop_sending();
  endtask

  task automatic test_back_to_back(input int count);
    stall_mode = 0;
    for (int i = 0; i < count; i++) send_cell(rand_cell(), 0);
    drain();  // hold off until every result is back
  endtask

  initial begin
    n_cycles = 0; n_errors = 0; n_cells = 0; n_results = 0;
    burst_left = 0; stall_mode = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_back_to_back(80);
    test_random(150, 1);
    test_random(120, 2);
    test_random(100, 0);
    drain();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d cells (%0d results): extremes, absent axes, ties, no-root,",
             n_cells, n_results);
    $display("zero-cost and saturating cases, back-to-back and bursty traffic with stalls.");
    if (n_errors == 0 && expected_potentials.size() == 0) begin
      $display("tb_eikonal_upwind_cell_update_core OK");
    end else begin
      $display("tb_eikonal_upwind_cell_update_core NOT OK");
    end
    $finish;
  end

endmodule
